@@ sv/erfc_pkg.sv @@
// Package: widths, constants, coefficient table and sideband types for the erfc pipeline.
`default_nettype none

package erfc_pkg;

  // Field and internal widths
  localparam int XW     = 32;            // argument / result width
  localparam int DW     = 32;            // 2^28 + |x|, i.e. 1 + |x|/2 in Q.28
  localparam int ZW     = 39;            // z*z in Q.30
  localparam int TW     = 31;            // t in Q.30, at most 1.0
  localparam int CW     = 32;            // coefficients, signed Q.30
  localparam int PW     = 35;            // Horner accumulator, signed Q.30
  localparam int MW     = PW - 1;        // accumulator magnitude
  localparam int HPW    = MW + TW;       // Horner product
  localparam int EW     = 42;            // exponent argument, signed Q.30
  localparam int QW     = 36;            // |e| during range reduction
  localparam int RW     = 30;            // reduced argument r, Q.30
  localparam int KW     = 6;             // power-of-two scale k
  localparam int SW     = 33;            // Taylor sum
  localparam int TAW    = TW + RW;       // term * r product
  localparam int RCW    = 33;            // reciprocal multiplier
  localparam int TBW    = 66;            // term divide product
  localparam int PRW    = 64;            // t * exp(r)
  localparam int ANS_W  = 34;            // scaled result before saturation

  // Pipeline shape
  localparam int DIV_STEPS    = 31;
  localparam int HORNER_STEPS = 9;
  localparam int EXP_TERMS    = 13;
  localparam int FRONT_STAGES = 3;
  localparam int RED_STAGES   = 4;
  localparam int TAIL_STAGES  = 4;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 2 * HORNER_STEPS
                              + RED_STAGES + 2 * EXP_TERMS + TAIL_STAGES;

  // Constants
  localparam logic [DW-1:0]        Q28_ONE  = DW'(64'd268435456);
  localparam logic [DW-1:0]        DIV_R0   = DW'(64'd134217728);
  localparam logic [TW-1:0]        Q30_ONE  = TW'(64'd1073741824);
  localparam logic [RW-1:0]        LN2_Q30  = RW'(64'd744261118);
  localparam logic signed [EW-1:0] E_FLOOR  = EW'(-64'sd34359738368);
  localparam logic [KW-1:0]        K_LIMIT  = KW'(32);
  localparam logic [ANS_W-1:0]     TWO_Q30  = ANS_W'(64'd2147483648);

  // Decimal constant scaled by 1e8, to Q.30 rounded half up
  function automatic longint q30c(longint n);
    return (n * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  endfunction

  function automatic logic signed [CW-1:0] coef(int idx);
    logic signed [CW-1:0] c;
    case (idx)
      0:       c = CW'(q30c(126551223));
      1:       c = CW'(q30c(100002368));
      2:       c = CW'(q30c(37409196));
      3:       c = CW'(q30c(9678418));
      4:       c = CW'(-q30c(18628806));
      5:       c = CW'(q30c(27886807));
      6:       c = CW'(-q30c(113520398));
      7:       c = CW'(q30c(148851587));
      8:       c = CW'(-q30c(82215223));
      9:       c = CW'(q30c(17087277));
      default: c = '0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic [DW-1:0] den;
    logic [ZW-1:0] zsq;
    logic          neg;
  } div_side_t;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [ZW-1:0] zsq;
    logic          neg;
  } hor_side_t;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [KW-1:0] k;
    logic          zero;
    logic          neg;
    logic [RW-1:0] r;
  } exp_side_t;

endpackage

`default_nettype wire

@@ sv/erfc_chebyshev_approx.sv @@
// Fully pipelined erfc(x) unit: Q4.27 argument in, Q2.30 result out.
// Throughput: one argument per cycle; a stall at the output freezes every stage.
// Reset (rst, synchronous): clears the stage valid bits only; data registers keep garbage.
// Most of the depth comes from the 31-step restoring divider for t and the 13-term exp series.
`default_nettype none

module erfc_chebyshev_approx (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   arg_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          erfc_value
);
  import erfc_pkg::*;

  localparam int DIV_LAST = FRONT_STAGES + DIV_STEPS - 1;

  // ---------------------------------------------------------------------------
  // Global pipeline advance. Every stage moves together; a stall holds all.
  // ---------------------------------------------------------------------------
  logic                  en;
  logic [NUM_STAGES-1:0] vld;

  assign en        = !vld[NUM_STAGES-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Front: z = |x|, den = 2^28 + z (so t = 2^58/den), z*z and its rounding.
  // ---------------------------------------------------------------------------
  logic [XW-1:0]  z_in;
  logic           s0_neg;
  logic [XW-1:0]  s0_z;
  logic [DW-1:0]  s0_den;
  logic [63:0]    s1_zz;
  logic [DW-1:0]  s1_den;
  logic           s1_neg;
  logic [63:0]    zz_rnd;
  div_side_t      s2_side;

  // -(-16.0) wraps to 2^31, which is the magnitude we want
  assign z_in = arg_value[XW-1] ? (XW'(~arg_value) + XW'(1)) : XW'(arg_value);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_neg <= arg_value[XW-1];
      s0_z   <= z_in;
      s0_den <= Q28_ONE + z_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_zz  <= 64'(s0_z) * 64'(s0_z);
      s1_den <= s0_den;
      s1_neg <= s0_neg;
    end
  end

  assign zz_rnd = s1_zz + 64'(1 << 23);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side.zsq <= zz_rnd[ZW+23:24];
      s2_side.den <= s1_den;
      s2_side.neg <= s1_neg;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage.
  // Numerator is 2^58 + den/2; its top part is 2^27 (< den), and the low
  // 31 bits are den >> 1, fed in MSB first.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] dv_r    [DIV_STEPS];
  logic [TW-1:0] dv_q    [DIV_STEPS];
  div_side_t     dv_side [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DW-1:0] r_in;
    logic [TW-1:0] q_in;
    div_side_t     side_in;
    logic [DW:0]   rs;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in    = DIV_R0;
      assign q_in    = '0;
      assign side_in = s2_side;
    end else begin : g_next
      assign r_in    = dv_r[k-1];
      assign q_in    = dv_q[k-1];
      assign side_in = dv_side[k-1];
    end

    assign rs = {r_in, side_in.den[DW-1-k]};
    assign ge = rs >= {1'b0, side_in.den};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k]    <= ge ? DW'(rs - {1'b0, side_in.den}) : DW'(rs);
        dv_q[k]    <= {q_in[TW-2:0], ge};
        dv_side[k] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Horner evaluation in t: multiply stage, then round/sign/add stage.
  // Last step forms e = p*t - c0 - z*z.
  // ---------------------------------------------------------------------------
  logic [HPW-1:0]        hm_prod [HORNER_STEPS];
  logic                  hm_sgn  [HORNER_STEPS];
  hor_side_t             hm_side [HORNER_STEPS];
  logic signed [PW-1:0]  ha_p    [HORNER_STEPS-1];
  hor_side_t             ha_side [HORNER_STEPS-1];
  logic signed [EW-1:0]  hx_e;
  logic [TW-1:0]         hx_t;
  logic                  hx_neg;

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic signed [PW-1:0] p_in;
    hor_side_t            side_in;
    logic [MW-1:0]        mag;
    logic [HPW:0]         rnd_full;
    logic [HPW-30:0]      rnd;
    logic signed [EW-1:0] mv;
    logic signed [EW-1:0] sv;

    if (j == 0) begin : g_first
      assign p_in        = PW'(coef(HORNER_STEPS));
      assign side_in.t   = dv_q[DIV_STEPS-1];
      assign side_in.zsq = dv_side[DIV_STEPS-1].zsq;
      assign side_in.neg = dv_side[DIV_STEPS-1].neg;
    end else begin : g_next
      assign p_in    = ha_p[j-1];
      assign side_in = ha_side[j-1];
    end

    assign mag = p_in[PW-1] ? MW'(-p_in) : MW'(p_in);

    always_ff @(posedge clk) begin
      if (en) begin
        hm_prod[j] <= HPW'(mag) * HPW'(side_in.t);
        hm_sgn[j]  <= p_in[PW-1];
        hm_side[j] <= side_in;
      end
    end

    // round half away from zero on the magnitude
    assign rnd_full = (HPW + 1)'(hm_prod[j]) + (HPW + 1)'(1 << 29);
    assign rnd      = rnd_full[HPW:30];
    assign mv       = EW'(rnd);
    assign sv       = hm_sgn[j] ? -mv : mv;

    if (j < HORNER_STEPS - 1) begin : g_acc
      always_ff @(posedge clk) begin
        if (en) begin
          ha_p[j]    <= PW'(sv + EW'(coef(HORNER_STEPS - 1 - j)));
          ha_side[j] <= hm_side[j];
        end
      end
    end else begin : g_exparg
      always_ff @(posedge clk) begin
        if (en) begin
          hx_e   <= sv - EW'(coef(0)) - EW'(hm_side[j].zsq);
          hx_t   <= hm_side[j].t;
          hx_neg <= hm_side[j].neg;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Range reduction: e = r - k*ln2, r in [0, ln2]. Quotient by ln2 is at most
  // 46, found by six compare/subtract steps split over two stages.
  // ---------------------------------------------------------------------------
  logic                 x0_under;
  logic                 x0_pos;
  logic [RW-1:0]        x0_rpos;
  logic [QW-1:0]        x0_m;
  logic [TW-1:0]        x0_t;
  logic                 x0_neg;
  logic [QW-1:0]        x1_m_c;
  logic [2:0]           x1_q_c;
  logic                 x1_under;
  logic                 x1_pos;
  logic [RW-1:0]        x1_rpos;
  logic [QW-1:0]        x1_m;
  logic [2:0]           x1_q;
  logic [TW-1:0]        x1_t;
  logic                 x1_neg;
  logic [QW-1:0]        x2_m_c;
  logic [2:0]           x2_q_c;
  logic                 x2_under;
  logic                 x2_pos;
  logic [RW-1:0]        x2_rpos;
  logic [QW-1:0]        x2_m;
  logic [KW-1:0]        x2_q;
  logic [TW-1:0]        x2_t;
  logic                 x2_neg;
  logic [KW-1:0]        x3_k_c;
  logic [RW-1:0]        x3_r_c;
  exp_side_t            x3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_under <= hx_e < E_FLOOR;
      x0_pos   <= !hx_e[EW-1];
      // only used when e >= 0; e above ln2 is clamped
      x0_rpos  <= (hx_e > EW'(LN2_Q30)) ? LN2_Q30 : RW'(hx_e);
      x0_m     <= QW'(-hx_e);
      x0_t     <= hx_t;
      x0_neg   <= hx_neg;
    end
  end

  always_comb begin
    x1_m_c = x0_m;
    x1_q_c = '0;
    for (int b = 5; b >= 3; b--) begin
      if (x1_m_c >= (QW'(LN2_Q30) << b)) begin
        x1_m_c        = x1_m_c - (QW'(LN2_Q30) << b);
        x1_q_c[b - 3] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_m     <= x1_m_c;
      x1_q     <= x1_q_c;
      x1_under <= x0_under;
      x1_pos   <= x0_pos;
      x1_rpos  <= x0_rpos;
      x1_t     <= x0_t;
      x1_neg   <= x0_neg;
    end
  end

  always_comb begin
    x2_m_c = x1_m;
    x2_q_c = '0;
    for (int b = 2; b >= 0; b--) begin
      if (x2_m_c >= (QW'(LN2_Q30) << b)) begin
        x2_m_c    = x2_m_c - (QW'(LN2_Q30) << b);
        x2_q_c[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_m     <= x2_m_c;
      x2_q     <= {x1_q, x2_q_c};
      x2_under <= x1_under;
      x2_pos   <= x1_pos;
      x2_rpos  <= x1_rpos;
      x2_t     <= x1_t;
      x2_neg   <= x1_neg;
    end
  end

  always_comb begin
    if (x2_pos) begin
      x3_k_c = '0;
      x3_r_c = x2_rpos;
    end else if (x2_m == '0) begin
      x3_k_c = x2_q;
      x3_r_c = '0;
    end else begin
      x3_k_c = x2_q + KW'(1);
      x3_r_c = LN2_Q30 - x2_m[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_side.t    <= x2_t;
      x3_side.k    <= x3_k_c;
      x3_side.r    <= x3_r_c;
      // far tail, or scale so large the rounded result is zero
      x3_side.zero <= x2_under || (x3_k_c >= K_LIMIT);
      x3_side.neg  <= x2_neg;
    end
  end

  // ---------------------------------------------------------------------------
  // exp(r) by Taylor series, two stages per term:
  //   term*r, then round and divide by i via reciprocal multiply.
  // ---------------------------------------------------------------------------
  logic [TAW-1:0] em_mul  [EXP_TERMS];
  logic [SW-1:0]  em_sum  [EXP_TERMS];
  exp_side_t      em_side [EXP_TERMS];
  logic [TBW-1:0] ed_mul  [EXP_TERMS];
  logic [SW-1:0]  ed_sum  [EXP_TERMS];
  exp_side_t      ed_side [EXP_TERMS];

  for (genvar n = 0; n < EXP_TERMS; n++) begin : g_exp
    localparam int I    = n + 1;
    localparam int HALF = I / 2;
    localparam int SH   = TW + $clog2(I);
    localparam int PSH  = TW + $clog2(n);
    localparam logic [RCW-1:0] RECIP = RCW'(((longint'(1) << SH) + I - 1) / I);

    logic [TW-1:0]  term_in;
    logic [SW-1:0]  sum_prev;
    exp_side_t      side_in;
    logic [TAW:0]   rnd_full;
    logic [TW-1:0]  xh;

    if (n == 0) begin : g_first
      assign term_in  = Q30_ONE;
      assign sum_prev = '0;
      assign side_in  = x3_side;
    end else begin : g_next
      assign term_in  = ed_mul[n-1][PSH+TW-1:PSH];
      assign sum_prev = ed_sum[n-1];
      assign side_in  = ed_side[n-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        em_mul[n]  <= TAW'(term_in) * TAW'(side_in.r);
        em_sum[n]  <= sum_prev + SW'(term_in);
        em_side[n] <= side_in;
      end
    end

    assign rnd_full = (TAW + 1)'(em_mul[n]) + (TAW + 1)'(1 << 29);
    assign xh       = rnd_full[TW+29:30] + TW'(HALF);

    always_ff @(posedge clk) begin
      if (en) begin
        ed_mul[n]  <= TBW'(xh) * TBW'(RECIP);
        ed_sum[n]  <= em_sum[n];
        ed_side[n] <= em_side[n];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tail: last term, t*exp(r), scale by 2^-(30+k) with rounding, reflect for
  // negative x and saturate.
  // ---------------------------------------------------------------------------
  localparam int LSH = TW + $clog2(EXP_TERMS);

  logic [SW-1:0]     f0_esum;
  exp_side_t         f0_side;
  logic [PRW-1:0]    f1_prod;
  exp_side_t         f1_side;
  logic [6:0]        f2_samt;
  logic [PRW-1:0]    f2_shv;
  logic [ANS_W+1:0]  f2_rnd;
  logic [ANS_W-1:0]  f2_ans;
  logic              f2_neg;
  logic [XW-1:0]     f3_res;

  always_ff @(posedge clk) begin
    if (en) begin
      f0_esum <= ed_sum[EXP_TERMS-1] + SW'(ed_mul[EXP_TERMS-1][LSH+TW-1:LSH]);
      f0_side <= ed_side[EXP_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod <= PRW'(f0_side.t) * PRW'(f0_esum);
      f1_side <= f0_side;
    end
  end

  // (prod + 2^(s-1)) >> s == ((prod >> (s-1)) + 1) >> 1, with s = 30 + k
  assign f2_samt = 7'(29) + 7'(f1_side.k);
  assign f2_shv  = f1_prod >> f2_samt;
  assign f2_rnd  = (ANS_W + 2)'(f2_shv[ANS_W:0]) + (ANS_W + 2)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      f2_ans <= f1_side.zero ? '0 : f2_rnd[ANS_W:1];
      f2_neg <= f1_side.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!f2_neg) begin
        f3_res <= (f2_ans > TWO_Q30) ? XW'(TWO_Q30) : XW'(f2_ans);
      end else begin
        f3_res <= (f2_ans >= TWO_Q30) ? '0 : XW'(TWO_Q30 - f2_ans);
      end
    end
  end

  assign erfc_value = f3_res;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("valid bits moved during stall");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_LAST] |-> dv_q[DIV_STEPS-1] <= Q30_ONE)
    else $error("divider quotient above 1.0");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> erfc_value <= XW'(TWO_Q30))
    else $error("result above 2.0");

endmodule

`default_nettype wire
